// ===== rtl/sfc_pkg.sv =====
// Shared constants, widths and codes for the sphere frustum classifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sfc_pkg;

   localparam int COORD_W    = 16;
   localparam int FRAC_BITS  = 14;
   localparam int NORM_W     = 16;
   localparam int NUM_PLANES = 6;
   localparam int PLANE_W    = 4 * NORM_W;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int TAG_W      = 16;
   localparam int VIS_W      = 2;
   localparam int RAD_W      = COORD_W - 1;
   localparam int CAM_W      = 3 * COORD_W;

   // plane term widths: a*x products and the offset d scaled by the fraction
   localparam int PROD_W   = COORD_W + NORM_W;
   localparam int DOFF_W   = NORM_W + FRAC_BITS;
   localparam int DIST_W   = ((PROD_W > DOFF_W) ? PROD_W : DOFF_W) + 2;

   // camera test widths
   localparam int SQ_W     = 2 * COORD_W;
   localparam int SQ_SUM_W = SQ_W + 2;
   localparam int RSQ_W    = 2 * RAD_W;

   localparam int PIPE_DEPTH = 4;

   typedef enum logic [VIS_W-1:0] {
      VIS_INSIDE    = 2'd0,
      VIS_INTERSECT = 2'd1,
      VIS_OUTSIDE   = 2'd2
   } vis_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLANE_0 = 3'd0,
      CSR_PLANE_1 = 3'd1,
      CSR_PLANE_2 = 3'd2,
      CSR_PLANE_3 = 3'd3,
      CSR_PLANE_4 = 3'd4,
      CSR_PLANE_5 = 3'd5,
      CSR_CAMERA  = 3'd6,
      CSR_FLAT    = 3'd7
   } csr_index_type;

endpackage

// ===== rtl/sfc_bus.sv =====
// Valid/ready channel interfaces: request, response and register write.
// Depends on sfc_pkg for field widths.
`timescale 1ns / 1ps

interface sfc_req_bus import sfc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   logic signed [COORD_W-1:0] center_z;
   logic        [RAD_W-1:0]   radius;
   logic        [TAG_W-1:0]   node_tag;

   modport source (output valid, center_x, center_y, center_z, radius, node_tag,
                   input ready);
   modport sink   (input valid, center_x, center_y, center_z, radius, node_tag,
                   output ready);
endinterface

interface sfc_rsp_bus import sfc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [TAG_W-1:0] result_tag;
   logic [VIS_W-1:0] visibility;

   modport source (output valid, result_tag, visibility, input ready);
   modport sink   (input valid, result_tag, visibility, output ready);
endinterface

interface sfc_csr_bus import sfc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/sphere_frustum_classifier.sv =====
// Sphere against six-plane frustum classifier, four register stages.
// Takes one request per cycle while the response side is not stalled.
// Stages: products, plane sums and squares, compares, result register.
// Each stage advances when the next one is empty or moving, so bubbles collapse.
// Synchronous reset empties the pipeline and clears planes, camera and flat mode.
`timescale 1ns / 1ps

module sphere_frustum_classifier import sfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sfc_req_bus.sink   req_if,
   sfc_rsp_bus.source rsp_if,
   sfc_csr_bus.sink   csr_if
);

   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] p,
                                                   input logic signed [COORD_W-1:0] q);
      logic signed [COORD_W:0] diff;
      diff = (COORD_W+1)'(p) - (COORD_W+1)'(q);
      return diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
   endfunction

   function automatic logic signed [NORM_W-1:0] plane_coef(input logic [PLANE_W-1:0] plane,
                                                          input int unsigned k);
      return plane[k*NORM_W +: NORM_W];
   endfunction

   // ---------------------------------------------------------------- registers
   logic [PLANE_W-1:0] plane_ff [NUM_PLANES];
   logic [CAM_W-1:0]   camera_ff;
   logic               flat_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         camera_ff <= '0;
         flat_ff   <= 1'b0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index) inside
            [CSR_PLANE_0:CSR_PLANE_5]: plane_ff[csr_if.index] <= csr_if.wdata[PLANE_W-1:0];
            CSR_CAMERA:                camera_ff <= csr_if.wdata[CAM_W-1:0];
            CSR_FLAT:                  flat_ff   <= csr_if.wdata[0];
            default:                   ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_if.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_if.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_if.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic signed [PROD_W-1:0] s1_prod_in [NUM_PLANES][3];
   logic signed [PROD_W-1:0] s1_prod_ff [NUM_PLANES][3];
   logic [COORD_W-1:0]       s1_dx_in, s1_dy_in, s1_dz_in;
   logic [COORD_W-1:0]       s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic                     s1_near_in, s1_near_ff;
   logic [RAD_W-1:0]         s1_rad_ff;
   logic [TAG_W-1:0]         s1_tag_ff;

   always_comb begin
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;
      cam_x = camera_ff[2*COORD_W +: COORD_W];
      cam_y = camera_ff[COORD_W +: COORD_W];
      cam_z = camera_ff[0 +: COORD_W];
      cy    = flat_ff ? '0 : req_if.center_y;
      for (int i = 0; i < NUM_PLANES; i++) begin
         s1_prod_in[i][0] = plane_coef(plane_ff[i], 3) * req_if.center_x;
         s1_prod_in[i][1] = plane_coef(plane_ff[i], 2) * cy;
         s1_prod_in[i][2] = plane_coef(plane_ff[i], 1) * req_if.center_z;
      end
      s1_dx_in   = abs_diff(cam_x, req_if.center_x);
      s1_dy_in   = flat_ff ? '0 : abs_diff(cam_y, req_if.center_y);
      s1_dz_in   = abs_diff(cam_z, req_if.center_z);
      s1_near_in = (s1_dx_in <= COORD_W'(req_if.radius)) &&
                   (s1_dy_in <= COORD_W'(req_if.radius)) &&
                   (s1_dz_in <= COORD_W'(req_if.radius));
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_prod_ff <= s1_prod_in;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_dz_ff   <= s1_dz_in;
         s1_near_ff <= s1_near_in;
         s1_rad_ff  <= req_if.radius;
         s1_tag_ff  <= req_if.node_tag;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [DIST_W-1:0] s2_dist_in [NUM_PLANES];
   logic signed [DIST_W-1:0] s2_dist_ff [NUM_PLANES];
   logic signed [DIST_W-1:0] s2_rs_in, s2_rs_ff;
   logic [SQ_W-1:0]          s2_sq_in [3];
   logic [SQ_W-1:0]          s2_sq_ff [3];
   logic [RSQ_W-1:0]         s2_rsq_in, s2_rsq_ff;
   logic                     s2_near_ff;
   logic [TAG_W-1:0]         s2_tag_ff;

   always_comb begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         s2_dist_in[i] = DIST_W'(s1_prod_ff[i][0]) + DIST_W'(s1_prod_ff[i][1]) +
                         DIST_W'(s1_prod_ff[i][2]) +
                         (DIST_W'(plane_coef(plane_ff[i], 0)) <<< FRAC_BITS);
      end
      s2_rs_in  = DIST_W'($signed({1'b0, s1_rad_ff})) <<< FRAC_BITS;
      s2_sq_in[0] = s1_dx_ff * s1_dx_ff;
      s2_sq_in[1] = s1_dy_ff * s1_dy_ff;
      s2_sq_in[2] = s1_dz_ff * s1_dz_ff;
      s2_rsq_in = s1_rad_ff * s1_rad_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_dist_ff <= s2_dist_in;
         s2_rs_ff   <= s2_rs_in;
         s2_sq_ff   <= s2_sq_in;
         s2_rsq_ff  <= s2_rsq_in;
         s2_near_ff <= s1_near_ff;
         s2_tag_ff  <= s1_tag_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic             s3_out_in, s3_out_ff;
   logic             s3_cut_in, s3_cut_ff;
   logic             s3_cam_in, s3_cam_ff;
   logic [TAG_W-1:0] s3_tag_ff;

   always_comb begin
      logic [SQ_SUM_W-1:0] sq_sum;
      s3_out_in = 1'b0;
      s3_cut_in = 1'b0;
      for (int i = 0; i < NUM_PLANES; i++) begin
         // fully beyond the plane, or straddling it within the radius
         if (s2_dist_ff[i] > 0 && s2_dist_ff[i] >= s2_rs_ff) s3_out_in = 1'b1;
         if (s2_dist_ff[i] < s2_rs_ff && s2_dist_ff[i] > -s2_rs_ff) s3_cut_in = 1'b1;
      end
      sq_sum    = SQ_SUM_W'(s2_sq_ff[0]) + SQ_SUM_W'(s2_sq_ff[1]) + SQ_SUM_W'(s2_sq_ff[2]);
      s3_cam_in = s2_near_ff && (sq_sum <= SQ_SUM_W'(s2_rsq_ff));
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_out_ff <= s3_out_in;
         s3_cut_ff <= s3_cut_in;
         s3_cam_ff <= s3_cam_in;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   vis_type          s4_vis_in, s4_vis_ff;
   logic [TAG_W-1:0] s4_tag_ff;

   always_comb begin
      // camera inside the sphere wins over every plane
      if (s3_cam_ff)      s4_vis_in = VIS_INTERSECT;
      else if (s3_out_ff) s4_vis_in = VIS_OUTSIDE;
      else if (s3_cut_ff) s4_vis_in = VIS_INTERSECT;
      else                s4_vis_in = VIS_INSIDE;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_vis_ff <= s4_vis_in;
         s4_tag_ff <= s3_tag_ff;
      end
   end

   assign rsp_if.valid      = v4_ff;
   assign rsp_if.result_tag = s4_tag_ff;
   assign rsp_if.visibility = s4_vis_ff;

endmodule

// ===== rtl/sfc_checker.sv =====
// Port-level checks for sphere_frustum_classifier, attached by bind.
// Depends on sfc_pkg for the pipeline depth and field widths.
`timescale 1ns / 1ps

module sfc_checker import sfc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [TAG_W-1:0] rsp_tag,
   input logic [VIS_W-1:0] rsp_vis
);

   localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

   logic [CNT_W-1:0] pending_ff, pending_in;

   // track requests taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready)   pending_in = pending_in + CNT_W'(1);
      if (rsp_valid && rsp_ready)   pending_in = pending_in - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tag) && $stable(rsp_vis))
      else $error("response dropped or changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind sphere_frustum_classifier sfc_checker u_sfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_tag   (rsp_if.result_tag),
   .rsp_vis   (rsp_if.visibility)
);

// ===== bench/sphere_frustum_classifier_tb.sv =====
// Self-checking bench for sphere_frustum_classifier: a directed table, then random spheres
// under several frustum settings, each response checked against a typed value or a local classifier.
// Depends on sfc_pkg and the channel interfaces in sfc_bus.
`timescale 1ns / 1ps

module sphere_frustum_classifier_tb import sfc_pkg::*; ();

   localparam int QUIET_LIMIT       = 1000;
   localparam int ITEMS_PER_SETTING = 60;
   localparam int DIR_ROWS          = 19;
   localparam int RANDOM_SETTINGS   = 8;

   localparam logic [NORM_W-1:0] ONE_Q     = 16'h4000;
   localparam logic [NORM_W-1:0] NEG_ONE_Q = 16'hC000;
   localparam logic [NORM_W-1:0] ZERO_Q    = 16'h0000;

   typedef enum logic [3:0] {
      AT_RESET,
      BOX_FIXED,
      BOX_FIXED_FLAT,
      BOX_RANDOM,
      BOX_RANDOM_FLAT,
      PLANES_ALL_ONES,
      PLANES_EXTREME,
      PLANES_NOISE,
      PLANES_TILTED,
      PLANES_CLEARED_FLAT
   } frustum_setting_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic        [RAD_W-1:0]   r;
      logic        [TAG_W-1:0]   tag;
   } sphere_req_type;

   typedef struct packed {
      frustum_setting_type setting;
      sphere_req_type      sphere;
      logic                typed;
      vis_type             vis;
   } sphere_row_type;

   typedef struct {
      logic [TAG_W-1:0] tag;
      vis_type          vis;
   } visibility_exp_type;

   logic clock;
   logic reset;
   logic rsp_take = 1'b0;
   logic [7:0] rx_phase = '0;

   // local copy of the block's registers, updated as each write is accepted
   logic [PLANE_W-1:0] plane_reg [NUM_PLANES];
   logic [CAM_W-1:0]   camera_reg;
   logic               flat_reg;

   visibility_exp_type pending_results [$];
   int error_count = 0;
   int quiet_cycles = 0;
   int near_span = 4000;
   int burst_left = 0;
   bit steady_traffic = 1'b0;

   sfc_req_bus req_bus ();
   sfc_rsp_bus rsp_bus ();
   sfc_csr_bus csr_bus ();

   sphere_frustum_classifier i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   assign rsp_bus.ready = rsp_take;

   // spheres at reset values are typed in; the rest are classified locally
   sphere_row_type directed_rows [DIR_ROWS] = '{
      '{AT_RESET, '{16'sd0, 16'sd0, 16'sd0, 15'd0, 16'h0000}, 1'b1, VIS_INTERSECT},
      '{AT_RESET, '{16'sd1, 16'sd0, 16'sd0, 15'd0, 16'hFFFF}, 1'b1, VIS_INSIDE},
      '{AT_RESET, '{16'sh8000, 16'sh8000, 16'sh8000, 15'h7FFF, 16'h1234}, 1'b1, VIS_INTERSECT},
      '{AT_RESET, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'd0, 16'h8001}, 1'b1, VIS_INSIDE},
      '{AT_RESET, '{16'sh7FFF, 16'sh8000, 16'sd0, 15'h7FFF, 16'h5555}, 1'b1, VIS_INTERSECT},
      '{AT_RESET, '{16'sd0, 16'sd0, 16'sd5, 15'd4, 16'hAAAA}, 1'b1, VIS_INTERSECT},
      '{BOX_FIXED, '{16'sd0, 16'sd0, 16'sd0, 15'd10, 16'h0101}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sd995, 16'sd0, 16'sd0, 15'd10, 16'h0102}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sd1010, 16'sd0, 16'sd0, 15'd10, 16'h0103}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sd1000, 16'sd0, 16'sd0, 15'd5, 16'h0104}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sd1001, 16'sd0, 16'sd0, 15'd0, 16'h0105}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sd1000, 16'sd0, 16'sd0, 15'd0, 16'h0106}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sd2000, 16'sd2000, 16'sd1995, 15'd5, 16'h0107}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sd0, -16'sd1005, 16'sd0, 15'h7FFF, 16'h0108}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED, '{16'sh8000, 16'sd0, 16'sd0, 15'd100, 16'h0109}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED_FLAT, '{16'sd0, 16'sd30000, 16'sd0, 15'd10, 16'h0201}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED_FLAT, '{16'sd2000, 16'sh8000, 16'sd1997, 15'd3, 16'h0202}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED_FLAT, '{16'sd0, 16'sd0, -16'sd1003, 15'd2, 16'h0203}, 1'b0, VIS_INSIDE},
      '{BOX_FIXED_FLAT, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 16'hFFFF}, 1'b0, VIS_INSIDE}
   };

   frustum_setting_type random_plan [RANDOM_SETTINGS] = '{
      BOX_RANDOM, BOX_RANDOM_FLAT, PLANES_ALL_ONES, PLANES_EXTREME,
      PLANES_NOISE, PLANES_TILTED, BOX_RANDOM, PLANES_CLEARED_FLAT
   };

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic vis_type predict_visibility(sphere_req_type s);
      longint x, y, z, r, rs, cam_x, cam_y, cam_z, dx, dy, dz, a, b, c, d, plane_dist;
      vis_type v;
      int i;
      x = s.x;
      y = flat_reg ? 0 : s.y;
      z = s.z;
      r = s.r;
      rs = r * (longint'(1) << FRAC_BITS);
      cam_x = $signed(camera_reg[3*COORD_W-1 -: COORD_W]);
      cam_y = $signed(camera_reg[2*COORD_W-1 -: COORD_W]);
      cam_z = $signed(camera_reg[COORD_W-1 -: COORD_W]);
      dx = (cam_x >= x) ? cam_x - x : x - cam_x;
      dy = flat_reg ? 0 : ((cam_y >= y) ? cam_y - y : y - cam_y);
      dz = (cam_z >= z) ? cam_z - z : z - cam_z;
      if (dx <= r && dy <= r && dz <= r && dx * dx + dy * dy + dz * dz <= r * r)
         return VIS_INTERSECT;
      v = VIS_INSIDE;
      for (i = 0; i < NUM_PLANES; i++) begin
         a = $signed(plane_reg[i][4*NORM_W-1 -: NORM_W]);
         b = $signed(plane_reg[i][3*NORM_W-1 -: NORM_W]);
         c = $signed(plane_reg[i][2*NORM_W-1 -: NORM_W]);
         d = $signed(plane_reg[i][NORM_W-1 -: NORM_W]);
         plane_dist = a * x + b * y + c * z + d * (longint'(1) << FRAC_BITS);
         if (plane_dist > 0) begin
            if (plane_dist >= rs)
               return VIS_OUTSIDE;
            v = VIS_INTERSECT;
         end else if (rs + plane_dist > 0) begin
            v = VIS_INTERSECT;
         end
      end
      return v;
   endfunction

   function automatic sphere_req_type random_sphere();
      sphere_req_type s;
      int pick;
      pick = $urandom_range(0, 9);
      s.tag = 16'($urandom);
      if (pick < 6) begin
         s.x = 16'($urandom_range(0, 2 * near_span) - near_span);
         s.y = 16'($urandom_range(0, 2 * near_span) - near_span);
         s.z = 16'($urandom_range(0, 2 * near_span) - near_span);
         s.r = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 1500));
      end else if (pick < 8) begin
         // close to the camera, to reach the camera test from both sides
         s.x = camera_reg[3*COORD_W-1 -: COORD_W] + 16'($urandom_range(0, 40)) - 16'd20;
         s.y = camera_reg[2*COORD_W-1 -: COORD_W] + 16'($urandom_range(0, 40)) - 16'd20;
         s.z = camera_reg[COORD_W-1 -: COORD_W] + 16'($urandom_range(0, 40)) - 16'd20;
         s.r = 15'($urandom_range(0, 40));
      end else begin
         s.x = 16'($urandom);
         s.y = 16'($urandom);
         s.z = 16'($urandom);
         s.r = 15'($urandom);
      end
      return s;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = data;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_CAMERA)
         camera_reg = data[CAM_W-1:0];
      else if (idx == CSR_FLAT)
         flat_reg = data[0];
      else
         plane_reg[idx] = data;
      @(negedge clock);
   endtask

   task automatic apply_setting(frustum_setting_type setting);
      logic [CSR_DATA_W-1:0] plane_words [NUM_PLANES];
      logic [CSR_DATA_W-1:0] cam_word;
      logic [NORM_W-1:0] neg_half;
      logic flat_bit;
      int half;
      int i;
      half = 0;
      flat_bit = 1'b0;
      near_span = 4000;
      cam_word = {$urandom, $urandom};
      for (i = 0; i < NUM_PLANES; i++)
         plane_words[i] = '0;
      case (setting) inside
         BOX_FIXED, BOX_FIXED_FLAT: begin
            half = 1000;
            cam_word = {16'h0000, 16'sd2000, 16'sd2000, 16'sd2000};
            flat_bit = (setting == BOX_FIXED_FLAT);
         end
         BOX_RANDOM, BOX_RANDOM_FLAT: begin
            half = $urandom_range(1, 20000);
            cam_word = {16'($urandom), 16'($urandom_range(0, 2 * half) - half),
                        16'($urandom_range(0, 2 * half) - half),
                        16'($urandom_range(0, 2 * half) - half)};
            flat_bit = (setting == BOX_RANDOM_FLAT);
         end
         PLANES_ALL_ONES: begin
            for (i = 0; i < NUM_PLANES; i++)
               plane_words[i] = '1;
            cam_word = {16'($urandom), 48'h7FFF_7FFF_7FFF};
            flat_bit = 1'($urandom);
         end
         PLANES_EXTREME: begin
            for (i = 0; i < NUM_PLANES; i++)
               plane_words[i] = i[0] ? 64'h7FFF_7FFF_7FFF_7FFF : 64'h8000_8000_8000_8000;
            cam_word = {16'hFFFF, 48'h8000_8000_8000};
         end
         PLANES_NOISE: begin
            for (i = 0; i < NUM_PLANES; i++)
               plane_words[i] = {$urandom, $urandom};
            flat_bit = 1'($urandom);
         end
         PLANES_TILTED: begin
            for (i = 0; i < NUM_PLANES; i++)
               plane_words[i] = {16'($urandom_range(0, 32768) - 16384),
                                 16'($urandom_range(0, 32768) - 16384),
                                 16'($urandom_range(0, 32768) - 16384),
                                 16'($urandom_range(0, 10000) - 5000)};
            near_span = 6000;
         end
         PLANES_CLEARED_FLAT: begin
            flat_bit = 1'b1;
         end
         default: begin
            cam_word = '0;
         end
      endcase
      if (half > 0) begin
         neg_half = NORM_W'(-half);
         plane_words[0] = {ONE_Q, ZERO_Q, ZERO_Q, neg_half};
         plane_words[1] = {NEG_ONE_Q, ZERO_Q, ZERO_Q, neg_half};
         plane_words[2] = {ZERO_Q, ZERO_Q, ONE_Q, neg_half};
         plane_words[3] = {ZERO_Q, ONE_Q, ZERO_Q, neg_half};
         plane_words[4] = {ZERO_Q, NEG_ONE_Q, ZERO_Q, neg_half};
         plane_words[5] = {ZERO_Q, ZERO_Q, NEG_ONE_Q, neg_half};
         near_span = half + 1500;
      end
      for (i = 0; i < NUM_PLANES; i++)
         write_reg(csr_index_type'(i), plane_words[i]);
      write_reg(CSR_CAMERA, cam_word);
      write_reg(CSR_FLAT, {$urandom, 31'($urandom), flat_bit});
      csr_bus.valid = 1'b0;
   endtask

   task automatic send_sphere(sphere_req_type s, logic typed, vis_type typed_vis);
      visibility_exp_type expected;
      int gap;
      if (!steady_traffic) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left--;
      end
      req_bus.valid    = 1'b1;
      req_bus.center_x = s.x;
      req_bus.center_y = s.y;
      req_bus.center_z = s.z;
      req_bus.radius   = s.r;
      req_bus.node_tag = s.tag;
      do @(posedge clock); while (!req_bus.ready);
      expected.tag = s.tag;
      expected.vis = typed ? typed_vis : predict_visibility(s);
      pending_results = {pending_results, expected};
      @(negedge clock);
   endtask

   // hold off until every response is back before a register write
   task automatic drain_responses();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   // receiver: free running, random stalls, free, one long stall, free again; the pattern repeats
   always @(negedge clock) begin
      rx_phase <= rx_phase + 8'd1;
      rsp_take <= !((rx_phase[7:6] == 2'b01 && $urandom_range(0, 2) == 0) ||
                    rx_phase[7:3] == 5'b10110);
   end

   always @(posedge clock) begin : check_results
      visibility_exp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result_tag: expected no response, got %h", rsp_bus.result_tag);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result_tag !== want.tag) begin
               $error("result_tag: expected %h, got %h", want.tag, rsp_bus.result_tag);
               error_count++;
            end
            if (rsp_bus.visibility !== want.vis) begin
               $error("visibility: expected %0d, got %0d (tag %h)",
                      want.vis, rsp_bus.visibility, want.tag);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("** sphere_frustum_classifier: FAILED **");
         $finish;
      end
   end

   initial begin
      frustum_setting_type current;
      int row;
      int k;
      int n;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.center_x = '0;
      req_bus.center_y = '0;
      req_bus.center_z = '0;
      req_bus.radius   = '0;
      req_bus.node_tag = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_PLANE_0;
      csr_bus.wdata    = '0;
      for (k = 0; k < NUM_PLANES; k++)
         plane_reg[k] = '0;
      camera_reg = '0;
      flat_reg   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      current = AT_RESET;
      for (row = 0; row < DIR_ROWS; row++) begin
         if (directed_rows[row].setting != current) begin
            drain_responses();
            current = directed_rows[row].setting;
            apply_setting(current);
         end
         send_sphere(directed_rows[row].sphere, directed_rows[row].typed,
                     directed_rows[row].vis);
      end

      for (k = 0; k < RANDOM_SETTINGS; k++) begin
         drain_responses();
         apply_setting(random_plan[k]);
         steady_traffic = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         for (n = 0; n < ITEMS_PER_SETTING; n++)
            send_sphere(random_sphere(), 1'b0, VIS_INSIDE);
      end

      req_bus.valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0)
         $display("** sphere_frustum_classifier: PASSED **");
      else
         $display("** sphere_frustum_classifier: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sfc_pkg.sv
rtl/sfc_bus.sv
rtl/sphere_frustum_classifier.sv
rtl/sfc_checker.sv
bench/sphere_frustum_classifier_tb.sv
